// File: hw/rtl/bshc_pkg.sv
// Shared types, codes and constants of the bit-sliced Hamming corrector.
package bshc_pkg;

	localparam int MAX_CODE_BITS_DEF = 16;
	localparam int WORD_BITS_DEF = 32;
	localparam int QUEUE_DEPTH = 2;

	localparam int CB_W = 5;
	localparam int IDX_W = 16;
	localparam int DATA_W = 32;
	localparam int ROW_W = 16;
	localparam int COL_W = 5;

	localparam logic [CB_W-1:0] CODE_BITS_RST = 5'd8;

	typedef enum logic [1:0] {
		FUNC_DATA   = 2'd0,
		FUNC_REF    = 2'd1,
		FUNC_READ   = 2'd2,
		FUNC_FINISH = 2'd3
	} func_t;

	typedef enum logic [1:0] {
		KIND_CODE  = 2'd0,
		KIND_FIX   = 2'd1,
		KIND_CLEAN = 2'd2,
		KIND_SIZE  = 2'd3
	} kind_t;

	// One classified item on its way from the front to the back.
	typedef struct packed {
		func_t              func;
		logic               row_err;
		logic               slot_ok;
		logic [IDX_W-1:0]   index;
		logic [DATA_W-1:0]  word;
	} cmd_t;

	// Clamp the configured code word count to the storage depth.
	function automatic logic [CB_W-1:0] used_words(input logic [CB_W-1:0] cb,
		input int unsigned max_bits);
		logic [CB_W-1:0] lim;
		lim = CB_W'(max_bits);
		return (cb > lim) ? lim : cb;
	endfunction

endpackage

// File: hw/rtl/bit_sliced_hamming_corrector.sv
// Bit-sliced Hamming corrector: accepts rows, reference codes, reads and finish beats.
// A result beat passes through the command queue and the output register of the back end.
// Data and reference beats are taken even while the output stalls; read and finish beats
// wait for a free output slot, and no beat is taken during the column scan. On finish with
// differing columns, the scan runs from column 0 to the last differing column.
// Reset: asynchronous; clears all code words, the size error and the queue, code_bits = 8.
module bit_sliced_hamming_corrector #(
	parameter int MAX_CODE_BITS = bshc_pkg::MAX_CODE_BITS_DEF,
	parameter int WORD_BITS = bshc_pkg::WORD_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [4:0]  cfg_wdata,      // code_bits
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [47:0] s_axis_tdata,   // index[15:0], word[47:16]
	input  logic [1:0]  s_axis_tuser,   // func[1:0]
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [55:0] m_axis_tdata,   // code_word[31:0], row[47:32], column[52:48], zero
	output logic [1:0]  m_axis_tuser,   // kind[1:0]
	output logic        m_axis_tlast
);

	logic [bshc_pkg::CB_W-1:0] code_bits_q;
	bshc_pkg::cmd_t            front_cmd;
	bshc_pkg::cmd_t            q_cmd;
	logic                      q_full;
	logic                      q_valid;
	logic                      q_pop;
	bshc_pkg::kind_t           out_kind;
	logic [bshc_pkg::DATA_W-1:0] out_code_word;
	logic [bshc_pkg::ROW_W-1:0]  out_row;
	logic [bshc_pkg::COL_W-1:0]  out_column;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			code_bits_q <= bshc_pkg::CODE_BITS_RST;
		end else if (cfg_we) begin
			code_bits_q <= cfg_wdata;
		end
	end

	assign s_axis_tready = !q_full;

	bshc_front #(
		.MAX_CODE_BITS(MAX_CODE_BITS)
	) u_front (
		.func      (s_axis_tuser),
		.index     (s_axis_tdata[15:0]),
		.word      (s_axis_tdata[47:16]),
		.code_bits (code_bits_q),
		.cmd       (front_cmd)
	);

	bshc_queue #(
		.DEPTH(bshc_pkg::QUEUE_DEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (s_axis_tvalid && s_axis_tready),
		.push_cmd (front_cmd),
		.full     (q_full),
		.pop      (q_pop),
		.q_valid  (q_valid),
		.q_cmd    (q_cmd)
	);

	bshc_back #(
		.MAX_CODE_BITS(MAX_CODE_BITS),
		.WORD_BITS(WORD_BITS)
	) u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.code_bits     (code_bits_q),
		.q_valid       (q_valid),
		.q_cmd         (q_cmd),
		.q_pop         (q_pop),
		.out_valid     (m_axis_tvalid),
		.out_ready     (m_axis_tready),
		.out_kind      (out_kind),
		.out_code_word (out_code_word),
		.out_row       (out_row),
		.out_column    (out_column),
		.out_last      (m_axis_tlast)
	);

	assign m_axis_tdata = {3'b000, out_column, out_row, out_code_word};
	assign m_axis_tuser = out_kind;

endmodule

// File: hw/rtl/bshc_front.sv
// Front end: decodes an incoming beat and checks its index ranges.
module bshc_front #(
	parameter int MAX_CODE_BITS = bshc_pkg::MAX_CODE_BITS_DEF
) (
	input  logic [1:0]                 func,
	input  logic [bshc_pkg::IDX_W-1:0] index,
	input  logic [bshc_pkg::DATA_W-1:0] word,
	input  logic [bshc_pkg::CB_W-1:0]  code_bits,
	output bshc_pkg::cmd_t             cmd
);

	logic [bshc_pkg::CB_W-1:0] n;

	assign n = bshc_pkg::used_words(code_bits, MAX_CODE_BITS);

	always_comb begin
		cmd.func = bshc_pkg::func_t'(func);
		// a row index needs no more than n bits
		cmd.row_err = (index >> n) != '0;
		cmd.slot_ok = {16'd0, index} < 32'(MAX_CODE_BITS);
		cmd.index = index;
		cmd.word = word;
	end

endmodule

// File: hw/rtl/bshc_queue.sv
// Short command queue between the front end and the back end.
module bshc_queue #(
	parameter int DEPTH = bshc_pkg::QUEUE_DEPTH
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  bshc_pkg::cmd_t push_cmd,
	output logic           full,
	input  logic           pop,
	output logic           q_valid,
	output bshc_pkg::cmd_t q_cmd
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	bshc_pkg::cmd_t  mem_q [DEPTH];
	logic [PW-1:0]   wr_ptr_q;
	logic [PW-1:0]   rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign full = count_q == CNT_W'(DEPTH);
	assign q_valid = count_q != '0;
	assign q_cmd = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_cmd;
		end
	end

endmodule

// File: hw/rtl/bshc_back.sv
// Back end: code word storage, row folding and the column scan on finish.
module bshc_back #(
	parameter int MAX_CODE_BITS = bshc_pkg::MAX_CODE_BITS_DEF,
	parameter int WORD_BITS = bshc_pkg::WORD_BITS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic [bshc_pkg::CB_W-1:0]   code_bits,
	input  logic                        q_valid,
	input  bshc_pkg::cmd_t              q_cmd,
	output logic                        q_pop,
	output logic                        out_valid,
	input  logic                        out_ready,
	output bshc_pkg::kind_t             out_kind,
	output logic [bshc_pkg::DATA_W-1:0] out_code_word,
	output logic [bshc_pkg::ROW_W-1:0]  out_row,
	output logic [bshc_pkg::COL_W-1:0]  out_column,
	output logic                        out_last
);

	localparam int COLS = (WORD_BITS < 32) ? WORD_BITS : 32;
	localparam int CW = $clog2(COLS);
	localparam int IW = (MAX_CODE_BITS > 1) ? $clog2(MAX_CODE_BITS) : 1;

	typedef enum logic [1:0] {
		ST_EXEC = 2'b01,
		ST_SCAN = 2'b10
	} st_t;

	st_t              state_q;
	logic [COLS-1:0]  comp_q [MAX_CODE_BITS];
	logic [COLS-1:0]  ref_q [MAX_CODE_BITS];
	logic             size_err_q;
	logic [COLS-1:0]  mask_q;
	logic [CW-1:0]    col_q;
	logic             out_valid_q;

	logic [bshc_pkg::CB_W-1:0] n;
	logic [COLS-1:0]           word_m;
	logic [COLS-1:0]           diff;
	logic [COLS-1:0]           mask_next;
	logic [MAX_CODE_BITS-1:0]  row_bits;
	logic [COLS-1:0]           rd_word;
	logic                      out_free;
	logic                      fix_emit;
	logic                      clr;
	logic                      emit;
	bshc_pkg::kind_t           e_kind;
	logic [bshc_pkg::DATA_W-1:0] e_cw;
	logic [bshc_pkg::ROW_W-1:0]  e_row;
	logic [bshc_pkg::COL_W-1:0]  e_col;
	logic                        e_last;

	function automatic logic CB_W_LT(input int j, input logic [bshc_pkg::CB_W-1:0] lim);
		return bshc_pkg::CB_W'(j) < lim;
	endfunction

	assign n = bshc_pkg::used_words(code_bits, MAX_CODE_BITS);
	assign word_m = q_cmd.word[COLS-1:0];
	assign out_free = !out_valid_q || out_ready;
	assign mask_next = mask_q & ~(COLS'(1) << col_q);
	assign rd_word = q_cmd.slot_ok ? comp_q[q_cmd.index[IW-1:0]] : '0;

	// columns where the computed and reference syndromes differ
	always_comb begin
		diff = '0;
		for (int j = 0; j < MAX_CODE_BITS; j++) begin
			if (CB_W_LT(j, n)) begin
				diff = diff | (comp_q[j] ^ ref_q[j]);
			end
		end
	end

	// syndrome difference of the current column
	always_comb begin
		for (int j = 0; j < MAX_CODE_BITS; j++) begin
			row_bits[j] = CB_W_LT(j, n) && (comp_q[j][col_q] ^ ref_q[j][col_q]);
		end
	end

	always_comb begin
		q_pop = 1'b0;
		if (state_q == ST_EXEC && q_valid) begin
			q_pop = out_free || q_cmd.func == bshc_pkg::FUNC_DATA
				|| q_cmd.func == bshc_pkg::FUNC_REF;
		end
	end

	assign fix_emit = state_q == ST_SCAN && mask_q[col_q] && out_free;

	always_comb begin
		emit = 1'b0;
		clr = 1'b0;
		e_kind = bshc_pkg::KIND_CODE;
		e_cw = '0;
		e_row = '0;
		e_col = '0;
		e_last = 1'b1;
		if (q_pop) begin
			case (q_cmd.func)
				bshc_pkg::FUNC_READ: begin
					emit = 1'b1;
					e_cw = bshc_pkg::DATA_W'(rd_word);
				end
				bshc_pkg::FUNC_FINISH: begin
					if (size_err_q) begin
						emit = 1'b1;
						clr = 1'b1;
						e_kind = bshc_pkg::KIND_SIZE;
					end else if (diff == '0) begin
						emit = 1'b1;
						clr = 1'b1;
						e_kind = bshc_pkg::KIND_CLEAN;
					end
				end
				default: ;
			endcase
		end
		if (fix_emit) begin
			emit = 1'b1;
			e_kind = bshc_pkg::KIND_FIX;
			e_row = bshc_pkg::ROW_W'(row_bits);
			e_col = bshc_pkg::COL_W'(col_q);
			e_last = mask_next == '0;
			clr = mask_next == '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_EXEC;
			size_err_q <= 1'b0;
			mask_q <= '0;
			col_q <= '0;
			out_valid_q <= 1'b0;
			for (int j = 0; j < MAX_CODE_BITS; j++) begin
				comp_q[j] <= '0;
				ref_q[j] <= '0;
			end
		end else begin
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_EXEC: begin
					if (q_pop) begin
						case (q_cmd.func)
							bshc_pkg::FUNC_DATA: begin
								if (q_cmd.row_err) begin
									size_err_q <= 1'b1;
								end else begin
									for (int j = 0; j < MAX_CODE_BITS; j++) begin
										if (CB_W_LT(j, n) && q_cmd.index[j]) begin
											comp_q[j] <= comp_q[j] ^ word_m;
										end
									end
								end
							end
							bshc_pkg::FUNC_REF: begin
								if (q_cmd.slot_ok) begin
									ref_q[q_cmd.index[IW-1:0]] <= word_m;
								end
							end
							bshc_pkg::FUNC_FINISH: begin
								if (!size_err_q && diff != '0) begin
									mask_q <= diff;
									col_q <= '0;
									state_q <= ST_SCAN;
								end
							end
							default: ;
						endcase
					end
				end
				ST_SCAN: begin
					// hold on a differing column until the output slot frees up
					if (!mask_q[col_q] || out_free) begin
						col_q <= col_q + 1'b1;
						mask_q <= mask_next;
						if (mask_next == '0) begin
							state_q <= ST_EXEC;
						end
					end
				end
				default: state_q <= ST_EXEC;
			endcase
			if (clr) begin
				size_err_q <= 1'b0;
				for (int j = 0; j < MAX_CODE_BITS; j++) begin
					comp_q[j] <= '0;
					ref_q[j] <= '0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			out_kind <= e_kind;
			out_code_word <= e_cw;
			out_row <= e_row;
			out_column <= e_col;
			out_last <= e_last;
		end
	end

	assign out_valid = out_valid_q;

endmodule

// File: sim/bit_sliced_hamming_corrector_tb.sv
// Self-checking testbench for the bit-sliced Hamming corrector, with its own predictor.
`timescale 1ns / 100ps

module bit_sliced_hamming_corrector_tb;

	localparam int CYCLE_LIMIT = 400000;
	localparam int DRAIN_CYCLES = 50;
	localparam int NUM_WORDS = 16;
	localparam int NUM_COLS = 32;

	typedef struct packed {
		bshc_pkg::kind_t kind;
		logic [31:0]     code_word;
		logic [15:0]     row;
		logic [4:0]      column;
		logic            last;
	} result_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_we = 1'b0;
	logic [4:0]  cfg_wdata = '0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [47:0] s_axis_tdata = '0;   // index[15:0], word[47:16]
	logic [1:0]  s_axis_tuser = '0;   // func[1:0]
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [55:0] m_axis_tdata;        // code_word[31:0], row[47:32], column[52:48], zero
	logic [1:0]  m_axis_tuser;        // kind[1:0]
	logic        m_axis_tlast;

	// predictor state
	logic [31:0] comp_codes [NUM_WORDS];
	logic [31:0] ref_codes [NUM_WORDS];
	logic        size_err;
	logic [4:0]  code_bits_m;

	logic [15:0] rdy_pat = 16'hFFFF;

	result_t due_beats[$];
	int errors = 0;
	int beats_sent = 0;
	int beats_seen = 0;
	int fixes_seen = 0;
	int size_seen = 0;
	int burst_left = 0;
	int cycle_cnt = 0;

	bit_sliced_hamming_corrector DUT (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.m_axis_tuser(m_axis_tuser),
		.m_axis_tlast(m_axis_tlast)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_cnt++;
		if (cycle_cnt >= CYCLE_LIMIT) begin
			$display("%0t: timeout with %0d result beats outstanding", $time, due_beats.size());
			$display("bit_sliced_hamming_corrector: mismatch");
			$finish;
		end
	end

	// receiver: stall on a random 16-bit ready pattern that is re-picked as the test runs
	always @(posedge clk) begin : rx_stall
		if (cycle_cnt % 64 == 0) begin
			rdy_pat = ($urandom_range(0, 3) == 0) ? 16'hFFFF : 16'($urandom());
			rdy_pat[0] = 1'b1;
		end
		m_axis_tready <= rdy_pat[cycle_cnt % 16];
	end

	function automatic int words_in_use();
		return (code_bits_m > 5'(NUM_WORDS)) ? NUM_WORDS : int'(code_bits_m);
	endfunction

	function automatic result_t beat(bshc_pkg::kind_t k, logic [31:0] cw, logic [15:0] r,
		logic [4:0] col, logic l);
		result_t b;
		b.kind = k;
		b.code_word = cw;
		b.row = r;
		b.column = col;
		b.last = l;
		return b;
	endfunction

	task automatic clear_codes();
		for (int j = 0; j < NUM_WORDS; j++) begin
			comp_codes[j] = '0;
			ref_codes[j] = '0;
		end
		size_err = 1'b0;
	endtask

	// fold one accepted beat into the code words and queue the results it causes
	task automatic fold_and_check(input bshc_pkg::func_t f, input logic [15:0] idx,
		input logic [31:0] w);
		int n;
		logic [15:0] a;
		logic [15:0] c;
		logic [15:0] syn_diff [NUM_COLS];
		logic [31:0] bad_cols;
		n = words_in_use();
		case (f)
			bshc_pkg::FUNC_DATA: begin
				if (int'(idx) >= (1 << n))
					size_err = 1'b1;
				else
					for (int b = 0; b < n; b++)
						if (idx[b])
							comp_codes[b] ^= w;
			end
			bshc_pkg::FUNC_REF: begin
				if (idx < 16'(NUM_WORDS))
					ref_codes[idx[3:0]] = w;
			end
			bshc_pkg::FUNC_READ: begin
				due_beats.push_back(beat(bshc_pkg::KIND_CODE,
					(idx < 16'(NUM_WORDS)) ? comp_codes[idx[3:0]] : 32'd0, '0, '0, 1'b1));
			end
			default: begin
				if (size_err) begin
					due_beats.push_back(beat(bshc_pkg::KIND_SIZE, '0, '0, '0, 1'b1));
				end else begin
					bad_cols = '0;
					for (int i = 0; i < NUM_COLS; i++) begin
						a = '0;
						c = '0;
						for (int j = 0; j < n; j++) begin
							a[j] = ref_codes[j][i];
							c[j] = comp_codes[j][i];
						end
						syn_diff[i] = a ^ c;
						bad_cols[i] = (a != c);
					end
					if (bad_cols == '0)
						due_beats.push_back(beat(bshc_pkg::KIND_CLEAN, '0, '0, '0, 1'b1));
					else
						for (int i = 0; i < NUM_COLS; i++)
							if (bad_cols[i])
								due_beats.push_back(beat(bshc_pkg::KIND_FIX, '0, syn_diff[i],
									5'(i), (bad_cols >> (i + 1)) == '0));
				end
				clear_codes();
			end
		endcase
	endtask

	// sender: bursts of random length separated by random gaps
	task automatic send_beat(input bshc_pkg::func_t f, input logic [15:0] idx,
		input logic [31:0] w);
		int gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
			if (gap > 0) begin
				s_axis_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(1, 12);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {w, idx};
		s_axis_tuser <= f;
		do @(posedge clk); while (!s_axis_tready);
		fold_and_check(f, idx, w);
		burst_left--;
		beats_sent++;
	endtask

	task automatic wait_idle();
		s_axis_tvalid <= 1'b0;
		burst_left = 0;
		while (due_beats.size() != 0) @(posedge clk);
		// trailing row and reference beats produce nothing; let them settle
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_code_bits(input logic [4:0] v);
		wait_idle();
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		code_bits_m = v;
	endtask

	always @(posedge clk) begin : check_results
		result_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			beats_seen++;
			if (due_beats.size() == 0) begin
				$display("%0t: unexpected result beat, expected none, got kind %0d tdata %h last %b",
					$time, m_axis_tuser, m_axis_tdata, m_axis_tlast);
				errors++;
			end else begin
				want = due_beats.pop_front();
				if (want.kind == bshc_pkg::KIND_FIX)
					fixes_seen++;
				if (want.kind == bshc_pkg::KIND_SIZE)
					size_seen++;
				if (bshc_pkg::kind_t'(m_axis_tuser) != want.kind) begin
					$display("%0t: kind expected %0d actual %0d", $time, want.kind, m_axis_tuser);
					errors++;
				end
				if (m_axis_tdata[31:0] != want.code_word) begin
					$display("%0t: code_word expected %h actual %h", $time, want.code_word,
						m_axis_tdata[31:0]);
					errors++;
				end
				if (m_axis_tdata[47:32] != want.row) begin
					$display("%0t: row expected %h actual %h", $time, want.row, m_axis_tdata[47:32]);
					errors++;
				end
				if (m_axis_tdata[52:48] != want.column) begin
					$display("%0t: column expected %0d actual %0d", $time, want.column,
						m_axis_tdata[52:48]);
					errors++;
				end
				if (m_axis_tlast != want.last) begin
					$display("%0t: last expected %b actual %b", $time, want.last, m_axis_tlast);
					errors++;
				end
			end
		end
	end

	// reads of an empty block, in and out of range, then finish on a clean block
	task automatic test_reads_after_reset();
		send_beat(bshc_pkg::FUNC_READ, 16'd0, 32'hFFFF_FFFF);
		send_beat(bshc_pkg::FUNC_READ, 16'd15, 32'h0);
		send_beat(bshc_pkg::FUNC_READ, 16'hFFFF, 32'hFFFF_FFFF);
		send_beat(bshc_pkg::FUNC_FINISH, 16'hFFFF, 32'hFFFF_FFFF);
	endtask

	// every column differs, row zero stays invisible, reference indexes beyond range
	task automatic test_all_columns_bad();
		send_beat(bshc_pkg::FUNC_DATA, 16'd255, 32'hFFFF_FFFF);
		send_beat(bshc_pkg::FUNC_DATA, 16'd0, 32'h1234_5678);
		send_beat(bshc_pkg::FUNC_REF, 16'd15, 32'hA5A5_A5A5);
		send_beat(bshc_pkg::FUNC_REF, 16'd16, 32'hFFFF_FFFF);
		send_beat(bshc_pkg::FUNC_READ, 16'd0, 32'h0);
		send_beat(bshc_pkg::FUNC_READ, 16'd7, 32'h0);
		send_beat(bshc_pkg::FUNC_READ, 16'd16, 32'h0);
		send_beat(bshc_pkg::FUNC_FINISH, 16'd0, 32'h0);
	endtask

	// out-of-range row masks all corrections; the next finish starts clean
	task automatic test_size_error();
		send_beat(bshc_pkg::FUNC_DATA, 16'd256, 32'h0000_0001);
		send_beat(bshc_pkg::FUNC_DATA, 16'd3, 32'h0000_0005);
		send_beat(bshc_pkg::FUNC_FINISH, 16'd0, 32'h0);
		send_beat(bshc_pkg::FUNC_FINISH, 16'd0, 32'h0);
	endtask

	// widest setting: top row, full word
	task automatic test_widest_row();
		write_code_bits(5'd16);
		send_beat(bshc_pkg::FUNC_DATA, 16'hFFFF, 32'hFFFF_FFFF);
		send_beat(bshc_pkg::FUNC_REF, 16'd0, 32'h0);
		send_beat(bshc_pkg::FUNC_FINISH, 16'd0, 32'h0);
	endtask

	// one sparse board: references from clean rows, rows sent with a few flipped bits
	task automatic send_board();
		int n;
		int span;
		int nrows;
		int mode;
		logic [15:0] ridx [6];
		logic [31:0] rword [6];
		logic [31:0] syn_ref [NUM_WORDS];
		logic [31:0] w;
		logic [15:0] ix;
		n = words_in_use();
		span = 1 << n;
		nrows = $urandom_range(1, 6);
		mode = $urandom_range(0, 9);
		for (int j = 0; j < NUM_WORDS; j++)
			syn_ref[j] = '0;
		for (int r = 0; r < nrows; r++) begin
			case ($urandom_range(0, 5))
				0: ridx[r] = '0;
				1: ridx[r] = 16'(span - 1);
				default: ridx[r] = 16'($urandom_range(0, span - 1));
			endcase
			rword[r] = $urandom();
			for (int j = 0; j < n; j++)
				if (ridx[r][j])
					syn_ref[j] ^= rword[r];
		end
		if (mode != 2)
			for (int j = 0; j < n; j++)
				send_beat(bshc_pkg::FUNC_REF, 16'(j), syn_ref[j]);
		for (int r = 0; r < nrows; r++) begin
			w = rword[r];
			if ($urandom_range(0, 2) == 0)
				w[$urandom_range(0, 31)] ^= 1'b1;
			if ($urandom_range(0, 7) == 0)
				w[$urandom_range(0, 31)] ^= 1'b1;
			send_beat(bshc_pkg::FUNC_DATA, ridx[r], w);
			if (mode == 0)
				send_beat(bshc_pkg::func_t'($urandom_range(0, 3)), 16'($urandom()), $urandom());
		end
		if (mode == 1 && n < NUM_WORDS)
			send_beat(bshc_pkg::FUNC_DATA, 16'($urandom_range(span, 65535)), $urandom());
		repeat ($urandom_range(0, 2)) begin
			ix = ($urandom_range(0, 3) == 0) ? 16'($urandom()) : 16'($urandom_range(0, 17));
			send_beat(bshc_pkg::FUNC_READ, ix, $urandom());
		end
		send_beat(bshc_pkg::FUNC_FINISH, 16'($urandom()), $urandom());
	endtask

	task automatic test_random_boards(input logic [4:0] cb, input int budget);
		int start;
		write_code_bits(cb);
		start = beats_sent;
		while (beats_sent - start < budget)
			send_board();
	endtask

	initial begin
		clear_codes();
		code_bits_m = bshc_pkg::CODE_BITS_RST;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reads_after_reset();
		test_all_columns_bad();
		test_size_error();
		test_widest_row();

		test_random_boards(5'd3, 60);
		test_random_boards(5'd16, 70);
		test_random_boards(5'd0, 40);
		test_random_boards(5'd31, 70);
		test_random_boards(5'd1, 50);
		test_random_boards(5'($urandom_range(2, 15)), 80);

		wait_idle();
		$display("covered %0d input beats and %0d result beats (%0d corrections, %0d size errors)",
			beats_sent, beats_seen, fixes_seen, size_seen);
		$display("code_bits settings: reset value, 16, 3, 0, 31, 1 and one random width");
		if (errors == 0 && due_beats.size() == 0)
			$display("bit_sliced_hamming_corrector: match");
		else
			$display("bit_sliced_hamming_corrector: mismatch");
		$finish;
	end

endmodule

// File: sim.f
hw/rtl/bshc_pkg.sv
hw/rtl/bshc_front.sv
hw/rtl/bshc_queue.sv
hw/rtl/bshc_back.sv
hw/rtl/bit_sliced_hamming_corrector.sv
sim/bit_sliced_hamming_corrector_tb.sv
